// ===== src/gclp_pkg.sv =====
// Shared types and constants for the G-code line parser.
`default_nettype none
package gclp_pkg;

  // Default number of characters scanned per line
  localparam int LINE_LIMIT_DEF = 99;

  // Result group codes
  localparam logic GRP_G = 1'b0;
  localparam logic GRP_M = 1'b1;

  typedef struct packed {
    logic        group;
    logic [6:0]  code;
    logic [31:0] arg;
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic        last;
  } res_t;

  // Results raised by one end of line, r0 goes out first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } emit_t;

endpackage
`default_nettype wire

// ===== src/gclp_scan.sv =====
// Character scanner, capture registers and end-of-line command decode.
`default_nettype none
module gclp_scan #(
  parameter int LINE_LIMIT = gclp_pkg::LINE_LIMIT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         stb,
  input  wire logic         kind,
  input  wire logic [7:0]   ch,
  output gclp_pkg::emit_t   emit
);

  localparam int CNT_W = $clog2(LINE_LIMIT + 1);

  localparam logic [2:0] MODE_BETWEEN = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_SIGNED  = 3'd2;
  localparam logic [2:0] MODE_INT     = 3'd3;
  localparam logic [2:0] MODE_FRAC    = 3'd4;
  localparam logic [2:0] MODE_SKIP    = 3'd5;
  localparam logic [2:0] MODE_ENDED   = 3'd6;

  localparam logic [2:0] LET_G = 3'd0;
  localparam logic [2:0] LET_M = 3'd1;
  localparam logic [2:0] LET_X = 3'd2;
  localparam logic [2:0] LET_Y = 3'd3;
  localparam logic [2:0] LET_F = 3'd4;
  localparam logic [2:0] LET_P = 3'd5;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [31:0] NEG_ONE  = 32'hFFFF_FFFF;
  localparam logic [6:0]  CODE_G0  = 7'd0;
  localparam logic [6:0]  CODE_G1  = 7'd1;
  localparam logic [6:0]  CODE_G4  = 7'd4;
  localparam logic [6:0]  CODE_G28 = 7'd28;

  // Signed 32-bit saturation of a magnitude with sign
  function automatic logic [31:0] sat_s(input logic [41:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 42'h0_8000_0000) res = 32'h8000_0000;
      else res = (~mag[31:0]) + 32'd1;
    end else begin
      if (mag > 42'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

  logic [2:0]       mode_r, mode_nxt;
  logic [2:0]       let_r, let_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      whole_r, whole_nxt;
  logic [9:0]       frac_r, frac_nxt;
  logic [1:0]       fdig_r, fdig_nxt;
  logic [31:0]      g_r, g_nxt;
  logic [31:0]      m_r, m_nxt;
  logic [31:0]      x_r, x_nxt;
  logic [31:0]      y_r, y_nxt;
  logic [31:0]      spd_r, spd_nxt;
  logic [31:0]      pau_r, pau_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic        is_char, is_eol, is_digit, in_num;
  logic [3:0]  dig;
  logic [35:0] whole_x10;
  logic [41:0] fixed_mag;
  logic [6:0]  fscale;
  logic [31:0] whole_sat, fixed_sat;
  logic        commit_c, commit_en;
  logic        g_hit, m_hit;
  gclp_pkg::res_t g_res, m_res;

  assign is_char  = stb && !kind && (cnt_r < CNT_W'(LINE_LIMIT));
  assign is_eol   = stb && kind;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig      = ch[3:0];
  assign in_num   = (mode_r == MODE_START) || (mode_r == MODE_SIGNED) ||
                    (mode_r == MODE_INT) || (mode_r == MODE_FRAC);

  // whole*10 + d, saturating at all ones
  assign whole_x10 = {whole_r, 3'b000} + {3'b000, whole_r, 1'b0} + {32'd0, dig};

  always_comb begin
    unique case (fdig_r)
      2'd1:    fscale = 7'd100;
      2'd2:    fscale = 7'd10;
      2'd3:    fscale = 7'd1;
      default: fscale = 7'd0;
    endcase
  end

  assign fixed_mag = ({10'd0, whole_r} * 42'd1000) + ({32'd0, frac_r} * {35'd0, fscale});
  assign whole_sat = sat_s({10'd0, whole_r}, neg_r);
  assign fixed_sat = sat_s(fixed_mag, neg_r);

  // Character scanner
  always_comb begin
    mode_nxt  = mode_r;
    let_nxt   = let_r;
    neg_nxt   = neg_r;
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;
    cnt_nxt   = cnt_r;
    commit_c  = 1'b0;
    if (is_char) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      unique case (mode_r)
        MODE_BETWEEN: begin
          if (ch == CH_SPACE) begin
            mode_nxt = MODE_BETWEEN;
          end else if (ch == CH_SEMI || ch == CH_NUL) begin
            mode_nxt = MODE_ENDED;
          end else if (ch == CH_G || ch == CH_M || ch == CH_X || ch == CH_Y ||
                       ch == CH_F || ch == CH_P) begin
            mode_nxt  = MODE_START;
            neg_nxt   = 1'b0;
            whole_nxt = '0;
            frac_nxt  = '0;
            fdig_nxt  = '0;
            if (ch == CH_G)      let_nxt = LET_G;
            else if (ch == CH_M) let_nxt = LET_M;
            else if (ch == CH_X) let_nxt = LET_X;
            else if (ch == CH_Y) let_nxt = LET_Y;
            else if (ch == CH_F) let_nxt = LET_F;
            else                 let_nxt = LET_P;
          end else begin
            mode_nxt = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (ch == CH_SPACE)    mode_nxt = MODE_BETWEEN;
          else if (ch == CH_NUL) mode_nxt = MODE_ENDED;
        end
        MODE_START, MODE_SIGNED, MODE_INT, MODE_FRAC: begin
          if (mode_r == MODE_START && (ch == CH_PLUS || ch == CH_MINUS)) begin
            neg_nxt  = (ch == CH_MINUS);
            mode_nxt = MODE_SIGNED;
          end else if (is_digit) begin
            if (mode_r == MODE_FRAC) begin
              if (fdig_r != 2'd3) begin
                frac_nxt = 10'({frac_r, 3'b000} + {1'b0, frac_r, 1'b0} + {9'd0, dig});
                fdig_nxt = fdig_r + 2'd1;
              end
            end else begin
              whole_nxt = (whole_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : whole_x10[31:0];
              mode_nxt  = MODE_INT;
            end
          end else if (ch == CH_DOT && mode_r != MODE_FRAC) begin
            mode_nxt = MODE_FRAC;
          end else begin
            commit_c = 1'b1;
            if (ch == CH_SPACE)    mode_nxt = MODE_BETWEEN;
            else if (ch == CH_NUL) mode_nxt = MODE_ENDED;
            else                   mode_nxt = MODE_SKIP;
          end
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // Capture update; at end of line the pending number is folded in first
  assign commit_en = commit_c || (is_eol && in_num);

  always_comb begin
    g_nxt   = (commit_en && let_r == LET_G) ? whole_sat : g_r;
    m_nxt   = (commit_en && let_r == LET_M) ? whole_sat : m_r;
    x_nxt   = (commit_en && let_r == LET_X) ? fixed_sat : x_r;
    y_nxt   = (commit_en && let_r == LET_Y) ? fixed_sat : y_r;
    spd_nxt = (commit_en && let_r == LET_F) ? whole_sat : spd_r;
    pau_nxt = (commit_en && let_r != LET_G && let_r != LET_M && let_r != LET_X &&
               let_r != LET_Y && let_r != LET_F) ? whole_sat : pau_r;
  end

  // End-of-line command decode from the updated captures
  always_comb begin
    g_hit       = 1'b1;
    g_res.group = gclp_pkg::GRP_G;
    g_res.code  = g_nxt[6:0];
    g_res.arg   = '0;
    g_res.x_pos = '0;
    g_res.y_pos = '0;
    g_res.last  = 1'b0;
    unique case (g_nxt)
      32'd0: begin
        g_res.x_pos = x_nxt;
        g_res.y_pos = y_nxt;
      end
      32'd1:   g_res.arg = spd_nxt;
      32'd4:   g_res.arg = pau_nxt;
      32'd28:  g_res.arg = '0;
      default: g_hit = 1'b0;
    endcase
    m_hit       = (m_nxt == 32'd106) || (m_nxt == 32'd107);
    m_res.group = gclp_pkg::GRP_M;
    m_res.code  = m_nxt[6:0];
    m_res.arg   = '0;
    m_res.x_pos = '0;
    m_res.y_pos = '0;
    m_res.last  = 1'b1;
    g_res.last  = !m_hit;

    emit.n  = is_eol ? (2'(g_hit) + 2'(m_hit)) : 2'd0;
    emit.r0 = g_hit ? g_res : m_res;
    emit.r1 = m_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || is_eol) begin
      mode_r  <= MODE_BETWEEN;
      let_r   <= LET_G;
      neg_r   <= 1'b0;
      whole_r <= '0;
      frac_r  <= '0;
      fdig_r  <= '0;
      g_r     <= NEG_ONE;
      m_r     <= NEG_ONE;
      x_r     <= '0;
      y_r     <= '0;
      spd_r   <= '0;
      pau_r   <= '0;
      cnt_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      let_r   <= let_nxt;
      neg_r   <= neg_nxt;
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      fdig_r  <= fdig_nxt;
      g_r     <= g_nxt;
      m_r     <= m_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      spd_r   <= spd_nxt;
      pau_r   <= pau_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Only the listed G codes ever leave the decoder
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit.n != 2'd0 && emit.r0.group == gclp_pkg::GRP_G) |->
      (emit.r0.code == CODE_G0 || emit.r0.code == CODE_G1 ||
       emit.r0.code == CODE_G4 || emit.r0.code == CODE_G28))
    else $error("gclp_scan: unexpected G code emitted");

endmodule
`default_nettype wire

// ===== src/gcode_line_parser.sv =====
// G-code line parser: top level with input register and result queue.
//
// Usage:
//   Input channel (in_valid/in_ready, in_kind, in_ch) carries one character
//   per transfer (in_kind = 0) or an end-of-line marker (in_kind = 1).
//   Result channel (out_valid/out_ready) carries decoded commands: the G
//   command (G0, G1, G4, G28) then the M command (M106, M107) of a line,
//   out_last set on the final result of the line. Lines without a known
//   code give no result.
//   A character is registered on transfer and scanned the next cycle. An
//   end-of-line marker passes the input register and the scanner's decode
//   into the result queue, from which its first result is shown on out_*.
//   Throughput: one item per cycle. The result queue holds four entries;
//   in_ready drops while more than two results wait, or while a staged
//   end-of-line marker still needs room for its two possible results, so a
//   stalled receiver backs up the input only after results pile up.
//   Reset (rst_n low, synchronous) empties the queue and the input register
//   and returns the scanner to the start of an empty line.
//   Only the first LINE_LIMIT characters of a line are scanned.
`default_nettype none
module gcode_line_parser #(
  parameter int LINE_LIMIT = gclp_pkg::LINE_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_ch,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_group,
  output      logic [6:0]  out_code,
  output      logic [31:0] out_arg,
  output      logic [31:0] out_x_pos,
  output      logic [31:0] out_y_pos,
  output      logic        out_last
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int QC_W  = $clog2(DEPTH + 1);

  // Input register
  logic       stg_v_r, stg_v_nxt;
  logic       stg_kind_r;
  logic [7:0] stg_ch_r;
  logic       in_xfer, out_xfer;

  gclp_pkg::emit_t emit;

  // Result queue
  gclp_pkg::res_t   q_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QC_W-1:0]  qcnt_r, qcnt_nxt;

  // Room for a staged end-of-line marker's results plus the item arriving now
  assign in_ready = ({1'b0, qcnt_r} + ((stg_v_r && stg_kind_r) ? (QC_W+1)'(2) : '0))
                    <= (QC_W+1)'(DEPTH - 2);
  assign in_xfer  = in_valid && in_ready;
  assign stg_v_nxt = in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_kind_r <= in_kind;
      stg_ch_r   <= in_ch;
    end
  end

  gclp_scan #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .stb   (stg_v_r),
    .kind  (stg_kind_r),
    .ch    (stg_ch_r),
    .emit  (emit)
  );

  assign out_valid = (qcnt_r != '0);
  assign out_xfer  = out_valid && out_ready;

  assign wptr_nxt = wptr_r + PTR_W'(emit.n);
  assign rptr_nxt = rptr_r + PTR_W'(out_xfer);
  assign qcnt_nxt = qcnt_r - QC_W'(out_xfer) + QC_W'(emit.n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      qcnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  // Up to two results written per cycle
  always_ff @(posedge clk) begin
    if (emit.n != 2'd0) begin
      q_r[wptr_r] <= emit.r0;
    end
    if (emit.n == 2'd2) begin
      q_r[wptr_r + PTR_W'(1)] <= emit.r1;
    end
  end

  assign out_group = q_r[rptr_r].group;
  assign out_code  = q_r[rptr_r].code;
  assign out_arg   = q_r[rptr_r].arg;
  assign out_x_pos = q_r[rptr_r].x_pos;
  assign out_y_pos = q_r[rptr_r].y_pos;
  assign out_last  = q_r[rptr_r].last;

  // Queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QC_W'(DEPTH))
    else $error("gcode_line_parser: result queue overflow");

  // A staged item always has room for both of its results
  assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r |-> (qcnt_r <= QC_W'(DEPTH - 2)))
    else $error("gcode_line_parser: staged item without queue room");

  // An M command is always the final result of its line
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_group == gclp_pkg::GRP_M) |-> out_last)
    else $error("gcode_line_parser: M result without last");

  // Queue bookkeeping matches the transfers
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit.n == 2'd0 && out_xfer) |=> (qcnt_r == $past(qcnt_r) - QC_W'(1)))
    else $error("gcode_line_parser: queue count mismatch");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for gcode_line_parser: directed lines, then random lines.
module tb;

  typedef gclp_pkg::res_t res_t;

  localparam int SCAN_LIMIT  = gclp_pkg::LINE_LIMIT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_ITEMS = 1500;
  localparam int RAND_CMDS   = 48;

  localparam logic GRP_G = gclp_pkg::GRP_G;
  localparam logic GRP_M = gclp_pkg::GRP_M;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  localparam logic [6:0] CODE_RAPID   = 7'd0;
  localparam logic [6:0] CODE_LINEAR  = 7'd1;
  localparam logic [6:0] CODE_DWELL   = 7'd4;
  localparam logic [6:0] CODE_HOME    = 7'd28;
  localparam logic [6:0] CODE_FAN_ON  = 7'd106;
  localparam logic [6:0] CODE_FAN_OFF = 7'd107;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AT    = 8'h40;  // stands for NUL in the directed table
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam res_t        NO_CMD  = '0;

  typedef enum logic [2:0] {
    SCAN_GAP, SCAN_LETTER, SCAN_SIGN, SCAN_WHOLE, SCAN_FRAC, SCAN_SKIP, SCAN_DONE
  } scan_e;
  typedef enum logic [2:0] {W_G, W_M, W_X, W_Y, W_F, W_P} word_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

  typedef struct {
    string text;
    int    n_typed;  // -1: take the line parser model's answer
    res_t  e0;
    res_t  e1;
  } line_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_group;
  logic [6:0]  out_code;
  logic [31:0] out_arg;
  logic [31:0] out_x_pos;
  logic [31:0] out_y_pos;
  logic        out_last;

  gcode_line_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_ch(in_ch),
    .out_valid(out_valid), .out_ready(out_ready), .out_group(out_group),
    .out_code(out_code), .out_arg(out_arg), .out_x_pos(out_x_pos),
    .out_y_pos(out_y_pos), .out_last(out_last)
  );

  always #6 clk = ~clk;

  // Line parser model state
  scan_e       ps_mode;
  word_e       ps_word;
  logic        ps_neg;
  logic [31:0] ps_whole;
  logic [9:0]  ps_frac;
  logic [1:0]  ps_fdig;
  logic [31:0] ps_g, ps_m, ps_x, ps_y, ps_feed, ps_dwell;
  int          ps_count;

  res_t        expected_cmds[$];
  line_case_t  dir_lines[$];
  logic [7:0]  line_buf[$];
  string       parser_chars = "GMXYFP0123456789.+-; ";
  int          mismatches = 0;
  int          cmds_predicted = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          no_gaps = 0;
  int          cycle_count = 0;
  int          rx_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  function automatic res_t mk_cmd(input logic grp, input logic [6:0] code,
                                  input logic [31:0] arg, input logic [31:0] x,
                                  input logic [31:0] y, input logic last);
    res_t r;
    r.group = grp;
    r.code  = code;
    r.arg   = arg;
    r.x_pos = x;
    r.y_pos = y;
    r.last  = last;
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] mag, input logic neg);
    if (neg) return (mag >= 64'h8000_0000) ? S32_MIN : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? S32_MAX : mag[31:0];
  endfunction

  function automatic void clear_line();
    ps_mode  = SCAN_GAP;
    ps_word  = W_G;
    ps_neg   = 1'b0;
    ps_whole = '0;
    ps_frac  = '0;
    ps_fdig  = '0;
    ps_g     = '1;
    ps_m     = '1;
    ps_x     = '0;
    ps_y     = '0;
    ps_feed  = '0;
    ps_dwell = '0;
    ps_count = 0;
  endfunction

  function automatic void commit_word();
    logic [31:0] whole;
    logic [63:0] scale, fixed;
    whole = sat32(64'(ps_whole), ps_neg);
    case (ps_fdig)
      2'd0: scale = 64'd0;
      2'd1: scale = 64'd100;
      2'd2: scale = 64'd10;
      default: scale = 64'd1;
    endcase
    fixed = 64'(ps_whole) * 64'd1000 + 64'(ps_frac) * scale;
    case (ps_word)
      W_G: ps_g = whole;
      W_M: ps_m = whole;
      W_X: ps_x = sat32(fixed, ps_neg);
      W_Y: ps_y = sat32(fixed, ps_neg);
      W_F: ps_feed = whole;
      default: ps_dwell = whole;
    endcase
  endfunction

  function automatic void open_word(input word_e w);
    ps_word  = w;
    ps_neg   = 1'b0;
    ps_whole = '0;
    ps_frac  = '0;
    ps_fdig  = '0;
    ps_mode  = SCAN_LETTER;
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic        is_digit;
    logic [63:0] w;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (ps_mode)
      SCAN_GAP: begin
        if (c == CH_SEMI || c == CH_NUL) ps_mode = SCAN_DONE;
        else if (c == CH_G) open_word(W_G);
        else if (c == CH_M) open_word(W_M);
        else if (c == CH_X) open_word(W_X);
        else if (c == CH_Y) open_word(W_Y);
        else if (c == CH_F) open_word(W_F);
        else if (c == CH_P) open_word(W_P);
        else if (c != CH_SPACE) ps_mode = SCAN_SKIP;
      end
      SCAN_SKIP: begin
        if (c == CH_SPACE) ps_mode = SCAN_GAP;
        else if (c == CH_NUL) ps_mode = SCAN_DONE;
      end
      SCAN_LETTER, SCAN_SIGN, SCAN_WHOLE, SCAN_FRAC: begin
        if (ps_mode == SCAN_LETTER && (c == CH_PLUS || c == CH_MINUS)) begin
          ps_neg  = (c == CH_MINUS);
          ps_mode = SCAN_SIGN;
        end else if (is_digit && ps_mode == SCAN_FRAC) begin
          // only three fraction digits count, the rest truncate
          if (ps_fdig < 2'd3) begin
            ps_frac = ps_frac * 10 + 10'(c - CH_ZERO);
            ps_fdig = ps_fdig + 2'd1;
          end
        end else if (is_digit) begin
          w = 64'(ps_whole) * 64'd10 + 64'(c - CH_ZERO);
          ps_whole = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
          ps_mode  = SCAN_WHOLE;
        end else if (c == CH_DOT && ps_mode != SCAN_FRAC) begin
          ps_mode = SCAN_FRAC;
        end else begin
          commit_word();
          if (c == CH_SPACE) ps_mode = SCAN_GAP;
          else if (c == CH_NUL) ps_mode = SCAN_DONE;
          else ps_mode = SCAN_SKIP;
        end
      end
      default: ;
    endcase
  endfunction

  // Returns the number of commands this item raises, in emission order.
  function automatic int decode_item(input logic kind, input logic [7:0] c,
                                     output res_t r0, output res_t r1);
    int   n;
    res_t fan;
    n  = 0;
    r0 = NO_CMD;
    r1 = NO_CMD;
    if (kind == KIND_CHAR) begin
      if (ps_count < SCAN_LIMIT) begin
        ps_count++;
        scan_char(c);
      end
      return 0;
    end
    if (ps_mode >= SCAN_LETTER && ps_mode <= SCAN_FRAC) commit_word();
    if (ps_g == 32'(CODE_RAPID)) begin
      r0 = mk_cmd(GRP_G, CODE_RAPID, '0, ps_x, ps_y, 1'b0);
      n  = 1;
    end else if (ps_g == 32'(CODE_LINEAR)) begin
      r0 = mk_cmd(GRP_G, CODE_LINEAR, ps_feed, '0, '0, 1'b0);
      n  = 1;
    end else if (ps_g == 32'(CODE_DWELL)) begin
      r0 = mk_cmd(GRP_G, CODE_DWELL, ps_dwell, '0, '0, 1'b0);
      n  = 1;
    end else if (ps_g == 32'(CODE_HOME)) begin
      r0 = mk_cmd(GRP_G, CODE_HOME, '0, '0, '0, 1'b0);
      n  = 1;
    end
    if (ps_m == 32'(CODE_FAN_ON) || ps_m == 32'(CODE_FAN_OFF)) begin
      fan = mk_cmd(GRP_M, ps_m[6:0], '0, '0, '0, 1'b0);
      if (n == 0) r0 = fan;
      else r1 = fan;
      n++;
    end
    if (n == 1) r0.last = 1'b1;
    if (n == 2) r1.last = 1'b1;
    clear_line();
    return n;
  endfunction

  task automatic add_case(input string t, input int n, input res_t a, input res_t b);
    line_case_t row;
    row.text    = t;
    row.n_typed = n;
    row.e0      = a;
    row.e1      = b;
    dir_lines.push_back(row);
  endtask

  // Drives one item in bursts; on transfer, logs what it should raise.
  task automatic push_item(input logic kind, input logic [7:0] c, input int n_typed,
                           input res_t t0, input res_t t1);
    int   gap;
    int   n;
    res_t r0, r1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_ch    <= c;
    do @(posedge clk); while (!in_ready);
    n = decode_item(kind, c, r0, r1);
    if (kind == KIND_EOL && n_typed >= 0) begin
      n  = n_typed;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) expected_cmds.push_back(r0);
    if (n > 1) expected_cmds.push_back(r1);
    cmds_predicted += n;
    @(negedge clk);
  endtask

  task automatic send_line(input int n_typed, input res_t t0, input res_t t1);
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (line_buf[i]) push_item(KIND_CHAR, line_buf[i], -1, NO_CMD, NO_CMD);
    push_item(KIND_EOL, 8'($urandom_range(0, 255)), n_typed, t0, t1);
    items_sent += line_buf.size() + 1;
  endtask

  task automatic put_digits(input int n);
    repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic put_number();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) line_buf.push_back(CH_MINUS);
    else if (r == 2) line_buf.push_back(CH_PLUS);
    put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4));
    if ($urandom_range(0, 1) == 1) begin
      line_buf.push_back(CH_DOT);
      put_digits($urandom_range(0, 5));
    end
  endtask

  // Known code, sometimes dressed with a sign, leading zero or fraction.
  task automatic put_code(input int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_PLUS);
    if ($urandom_range(0, 5) == 0) line_buf.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    if ($urandom_range(0, 7) == 0) begin
      line_buf.push_back(CH_DOT);
      put_digits($urandom_range(0, 2));
    end
  endtask

  task automatic make_random_line();
    int style, ntok, pick;
    line_buf.delete();
    style = $urandom_range(0, 9);
    if (style < 7) begin
      // well-formed words with random content
      if ($urandom_range(0, 14) == 0)
        repeat ($urandom_range(90, 104)) line_buf.push_back(CH_SPACE);
      ntok = $urandom_range(0, 5);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0 || $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
        pick = $urandom_range(0, 12);
        case (pick)
          0, 1, 2: begin
            line_buf.push_back(CH_G);
            if ($urandom_range(0, 4) == 0) put_number();
            else begin
              case ($urandom_range(0, 3))
                0: put_code(CODE_RAPID);
                1: put_code(CODE_LINEAR);
                2: put_code(CODE_DWELL);
                default: put_code(CODE_HOME);
              endcase
            end
          end
          3, 4: begin
            line_buf.push_back(CH_M);
            if ($urandom_range(0, 3) == 0) put_number();
            else put_code(($urandom_range(0, 1) == 1) ? CODE_FAN_ON : CODE_FAN_OFF);
          end
          5, 6: begin line_buf.push_back(CH_X); put_number(); end
          7, 8: begin line_buf.push_back(CH_Y); put_number(); end
          9:    begin line_buf.push_back(CH_F); put_number(); end
          10:   begin line_buf.push_back(CH_P); put_number(); end
          11: begin
            line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
            put_number();
          end
          default: begin
            line_buf.push_back(CH_SEMI);
            repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
          end
        endcase
        if ($urandom_range(0, 19) == 0)
          line_buf.push_back(($urandom_range(0, 1) == 1) ? CH_NUL : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
    end else if (style < 9) begin
      repeat ($urandom_range(0, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // broken words drawn from the parser's own alphabet
      repeat ($urandom_range(0, 30))
        line_buf.push_back(parser_chars[$urandom_range(0, parser_chars.len() - 1)]);
    end
  endtask

  // Receiver: ready pattern switches between open, coin flip, sparse and hold
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 48);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result: group %0d code %0d", out_group, out_code);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        if (out_group !== want.group) begin
          $error("out_group: expected %0d, got %0d", want.group, out_group);
          mismatches++;
        end
        if (out_code !== want.code) begin
          $error("out_code: expected %0d, got %0d", want.code, out_code);
          mismatches++;
        end
        if (out_arg !== want.arg) begin
          $error("out_arg: expected %0d, got %0d", $signed(want.arg), $signed(out_arg));
          mismatches++;
        end
        if (out_x_pos !== want.x_pos) begin
          $error("out_x_pos: expected %0d, got %0d", $signed(want.x_pos), $signed(out_x_pos));
          mismatches++;
        end
        if (out_y_pos !== want.y_pos) begin
          $error("out_y_pos: expected %0d, got %0d", $signed(want.y_pos), $signed(out_y_pos));
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    string      pad;
    line_case_t row;
    logic [7:0] c;
    int         cmds_at_start;

    clear_line();
    pad = "";
    repeat (96) pad = {pad, " "};

    add_case("", 0, NO_CMD, NO_CMD);
    add_case("G0 X10.5 Y-2.25", 1,
             mk_cmd(GRP_G, CODE_RAPID, '0, 32'd10500, -32'sd2250, 1'b1), NO_CMD);
    add_case("G1 F1500 M106", 2, mk_cmd(GRP_G, CODE_LINEAR, 32'd1500, '0, '0, 1'b0),
             mk_cmd(GRP_M, CODE_FAN_ON, '0, '0, '0, 1'b1));
    add_case("G4 P250", 1, mk_cmd(GRP_G, CODE_DWELL, 32'd250, '0, '0, 1'b1), NO_CMD);
    add_case("G28 X5", 1, mk_cmd(GRP_G, CODE_HOME, '0, '0, '0, 1'b1), NO_CMD);
    add_case("M107", 1, mk_cmd(GRP_M, CODE_FAN_OFF, '0, '0, '0, 1'b1), NO_CMD);
    add_case("G0 X2147483.647 Y-2147483.648", 1,
             mk_cmd(GRP_G, CODE_RAPID, '0, S32_MAX, S32_MIN, 1'b1), NO_CMD);
    add_case("G0 X99999999999 Y-4294967296.5", 1,
             mk_cmd(GRP_G, CODE_RAPID, '0, S32_MAX, S32_MIN, 1'b1), NO_CMD);
    add_case("G1 F-5000000000", 1, mk_cmd(GRP_G, CODE_LINEAR, S32_MIN, '0, '0, 1'b1), NO_CMD);
    add_case("G4 P4294967295", 1, mk_cmd(GRP_G, CODE_DWELL, S32_MAX, '0, '0, 1'b1), NO_CMD);
    add_case("G0 X1.23456 Y.5", 1,
             mk_cmd(GRP_G, CODE_RAPID, '0, 32'd1234, 32'd500, 1'b1), NO_CMD);
    add_case("G0 X- Y+", 1, mk_cmd(GRP_G, CODE_RAPID, '0, '0, '0, 1'b1), NO_CMD);
    add_case("G0 X-0.001", 1, mk_cmd(GRP_G, CODE_RAPID, '0, -32'sd1, '0, 1'b1), NO_CMD);
    add_case("G0 G1 F7", 1, mk_cmd(GRP_G, CODE_LINEAR, 32'd7, '0, '0, 1'b1), NO_CMD);
    add_case("G1 F5 M106 M7", 1, mk_cmd(GRP_G, CODE_LINEAR, 32'd5, '0, '0, 1'b1), NO_CMD);
    // semicolon inside a word only ends the number
    add_case("G1 F12;x", 1, mk_cmd(GRP_G, CODE_LINEAR, 32'd12, '0, '0, 1'b1), NO_CMD);
    add_case("; G1 F5", 0, NO_CMD, NO_CMD);
    add_case("g1 f5 M107", 1, mk_cmd(GRP_M, CODE_FAN_OFF, '0, '0, '0, 1'b1), NO_CMD);
    // '@' becomes NUL: pending number commits, rest of line ignored
    add_case("G1 F3@ M106", 1, mk_cmd(GRP_G, CODE_LINEAR, 32'd3, '0, '0, 1'b1), NO_CMD);
    add_case("@G1 F2", 0, NO_CMD, NO_CMD);
    // line cut off right after G28
    add_case({pad, "G28 M106"}, 1, mk_cmd(GRP_G, CODE_HOME, '0, '0, '0, 1'b1), NO_CMD);
    add_case("G2 M105", 0, NO_CMD, NO_CMD);
    add_case("X5 Y-6 G0", 1,
             mk_cmd(GRP_G, CODE_RAPID, '0, 32'd5000, -32'sd6000, 1'b1), NO_CMD);
    add_case("  G1.9   F1.2.3   ", -1, NO_CMD, NO_CMD);
    add_case("M106.5 G04 P-3 Q7", -1, NO_CMD, NO_CMD);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_lines[i]) begin
      row = dir_lines[i];
      line_buf.delete();
      for (int k = 0; k < row.text.len(); k++) begin
        c = row.text[k];
        line_buf.push_back((c == CH_AT) ? CH_NUL : c);
      end
      send_line(row.n_typed, row.e0, row.e1);
    end

    cmds_at_start = cmds_predicted;
    while (items_sent < TOTAL_ITEMS || cmds_predicted - cmds_at_start < RAND_CMDS) begin
      make_random_line();
      send_line(-1, NO_CMD, NO_CMD);
    end
    in_valid <= 1'b0;

    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
